// ===== rtl/tlic_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-level interrupt controller package
// Transfer types, operation codes and register map shared by the RTL.
// ----------------------------------------------------------------------------
package tlic_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  reg_offset;
        logic [31:0] write_data;
        logic [6:0]  source_index;
    } in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        level6_pending;
        logic        level4_pending;
        logic        level2_pending;
        logic        source_raised;
    } out_t;

    // Status groups selected by source_index[6:5]
    localparam logic [1:0] GRP_NORMAL   = 2'd0;
    localparam logic [1:0] GRP_EXTERNAL = 2'd1;
    localparam logic [1:0] GRP_ERROR    = 2'd2;
    localparam logic [1:0] GRP_NONE     = 2'd3;

    // Register map (byte offsets)
    localparam logic [5:0] OFS_NORMAL   = 6'h00;
    localparam logic [5:0] OFS_EXTERNAL = 6'h04;
    localparam logic [5:0] OFS_ERROR    = 6'h08;
    localparam logic [5:0] OFS_L2_NRM   = 6'h10;
    localparam logic [5:0] OFS_L2_EXT   = 6'h14;
    localparam logic [5:0] OFS_L2_ERR   = 6'h18;
    localparam logic [5:0] OFS_L4_NRM   = 6'h20;
    localparam logic [5:0] OFS_L4_EXT   = 6'h24;
    localparam logic [5:0] OFS_L4_ERR   = 6'h28;
    localparam logic [5:0] OFS_L6_NRM   = 6'h30;
    localparam logic [5:0] OFS_L6_EXT   = 6'h34;
    localparam logic [5:0] OFS_L6_ERR   = 6'h38;

    localparam int unsigned MASK_COUNT = 9;

    localparam logic [31:0] LOW30_MASK      = 32'h3FFF_FFFF;
    localparam logic [31:0] EXT_SUMMARY_BIT = 32'h4000_0000;
    localparam logic [31:0] ERR_SUMMARY_BIT = 32'h8000_0000;

endpackage

// ===== rtl/three_level_interrupt_controller_top.sv =====
// ----------------------------------------------------------------------------
// Three-level interrupt controller
// Normal, external and error status with nine level masks behind a bus port.
// ----------------------------------------------------------------------------
// Each input transfer is a bus read, a bus write, a source raise or a source
// clear; each produces exactly one result transfer carrying the read data
// (zero for anything but a read), the three level pending lines after the
// item and the status bit of the given source after the item. The block
// takes one item per cycle unless the result is held by out_ready; each
// item waits in the input register, then takes a single pass of decode,
// status update and mask reduction into the result register. The status and
// mask registers are written on that same pass, so an item always sees the
// effect of the one before it. Reset clears every status and mask register.
// Sources 96 to 127 leave status untouched and report not raised.
module three_level_interrupt_controller_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlic_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output tlic_pkg::out_t  out_data
);

    // Input register stage
    logic           s1_valid_reg;
    tlic_pkg::in_t  s1_data_reg;

    // Result register stage
    logic           out_valid_reg;
    tlic_pkg::out_t out_data_reg;

    // Architectural state
    logic [31:0] nrm_reg, nrm_next;
    logic [31:0] ext_reg, ext_next;
    logic [31:0] err_reg, err_next;
    logic [31:0] mask_reg  [tlic_pkg::MASK_COUNT];
    logic [31:0] mask_next [tlic_pkg::MASK_COUNT];

    logic           advance;
    logic           mask_hit;
    logic [3:0]     mask_idx;
    logic [31:0]    src_bit;
    logic [1:0]     src_grp;
    logic [31:0]    rd_value;
    tlic_pkg::out_t result;

    // Advance the item in the input register when the result slot is free
    // or is being emptied in this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign src_grp = s1_data_reg.source_index[6:5];
    assign src_bit = 32'd1 << s1_data_reg.source_index[4:0];

    // Decode a mask offset into its index: levels 2, 4, 6 in groups of three,
    // normal, external, error within a level.
    always_comb
    begin
        mask_hit = 1'b1;
        mask_idx = 4'd0;
        case (s1_data_reg.reg_offset)
            tlic_pkg::OFS_L2_NRM: mask_idx = 4'd0;
            tlic_pkg::OFS_L2_EXT: mask_idx = 4'd1;
            tlic_pkg::OFS_L2_ERR: mask_idx = 4'd2;
            tlic_pkg::OFS_L4_NRM: mask_idx = 4'd3;
            tlic_pkg::OFS_L4_EXT: mask_idx = 4'd4;
            tlic_pkg::OFS_L4_ERR: mask_idx = 4'd5;
            tlic_pkg::OFS_L6_NRM: mask_idx = 4'd6;
            tlic_pkg::OFS_L6_EXT: mask_idx = 4'd7;
            tlic_pkg::OFS_L6_ERR: mask_idx = 4'd8;
            default:              mask_hit = 1'b0;
        endcase
    end

    // Bus read view of the current state; normal status carries the two
    // summary bits in its top positions.
    always_comb
    begin
        case (s1_data_reg.reg_offset)
            tlic_pkg::OFS_NORMAL:
                rd_value = (nrm_reg & tlic_pkg::LOW30_MASK)
                         | ((ext_reg != 32'd0) ? tlic_pkg::EXT_SUMMARY_BIT : 32'd0)
                         | ((err_reg != 32'd0) ? tlic_pkg::ERR_SUMMARY_BIT : 32'd0);
            tlic_pkg::OFS_EXTERNAL: rd_value = ext_reg;
            tlic_pkg::OFS_ERROR:    rd_value = err_reg;
            default:                rd_value = mask_hit ? mask_reg[mask_idx] : 32'd0;
        endcase
    end

    // State update for the item in the input register
    always_comb
    begin
        nrm_next  = nrm_reg;
        ext_next  = ext_reg;
        err_next  = err_reg;
        mask_next = mask_reg;
        case (s1_data_reg.mode)
            tlic_pkg::MODE_READ:
            begin
            end
            tlic_pkg::MODE_WRITE:
            begin
                // Ones clear status; external status is read only
                if (s1_data_reg.reg_offset == tlic_pkg::OFS_NORMAL)
                    nrm_next = nrm_reg & ~s1_data_reg.write_data;
                else if (s1_data_reg.reg_offset == tlic_pkg::OFS_ERROR)
                    err_next = err_reg & ~s1_data_reg.write_data;
                else if (mask_hit)
                    mask_next[mask_idx] = s1_data_reg.write_data;
            end
            tlic_pkg::MODE_RAISE:
            begin
                case (src_grp)
                    tlic_pkg::GRP_NORMAL:   nrm_next = nrm_reg | src_bit;
                    tlic_pkg::GRP_EXTERNAL: ext_next = ext_reg | src_bit;
                    tlic_pkg::GRP_ERROR:    err_next = err_reg | src_bit;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                case (src_grp)
                    tlic_pkg::GRP_NORMAL:   nrm_next = nrm_reg & ~src_bit;
                    tlic_pkg::GRP_EXTERNAL: ext_next = ext_reg & ~src_bit;
                    tlic_pkg::GRP_ERROR:    err_next = err_reg & ~src_bit;
                    default:
                    begin
                    end
                endcase
            end
        endcase
    end

    // Result from the state after the item
    always_comb
    begin
        result.read_data = (s1_data_reg.mode == tlic_pkg::MODE_READ) ? rd_value : 32'd0;
        result.level2_pending = |((nrm_next & mask_next[0]) | (ext_next & mask_next[1])
                                | (err_next & mask_next[2]));
        result.level4_pending = |((nrm_next & mask_next[3]) | (ext_next & mask_next[4])
                                | (err_next & mask_next[5]));
        result.level6_pending = |((nrm_next & mask_next[6]) | (ext_next & mask_next[7])
                                | (err_next & mask_next[8]));
        case (src_grp)
            tlic_pkg::GRP_NORMAL:   result.source_raised = |(nrm_next & src_bit);
            tlic_pkg::GRP_EXTERNAL: result.source_raised = |(ext_next & src_bit);
            tlic_pkg::GRP_ERROR:    result.source_raised = |(err_next & src_bit);
            default:                result.source_raised = 1'b0;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            nrm_reg       <= 32'd0;
            ext_reg       <= 32'd0;
            err_reg       <= 32'd0;
            for (int i = 0; i < tlic_pkg::MASK_COUNT; i++)
                mask_reg[i] <= 32'd0;
        end
        else
        begin
            // Hold the input stage full until it advances; refill on transfer
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                nrm_reg       <= nrm_next;
                ext_reg       <= ext_next;
                err_reg       <= err_next;
                mask_reg      <= mask_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

endmodule
